// ----- rtl/itrd_pkg.sv -----
package itrd_pkg;

    localparam int MAX_BASE    = 16;
    localparam int MAX_DIGITS  = 64;
    localparam int NUM_SYMBOLS = 16;
    localparam int VALUE_W     = 64;
    localparam int HALF_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = $clog2(MAX_BASE);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_W);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [BASE_W-1:0]  RST_BASE_LEN = 5'd10;
    localparam logic [VALUE_W-1:0] RST_ALPHA_LO = 64'h3736353433323130;
    localparam logic [VALUE_W-1:0] RST_ALPHA_HI = 64'h0000000000003938;

    localparam logic OP_SIGNED32   = 1'b0;
    localparam logic OP_UNSIGNED64 = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LEN  = 2'd0,
        CFG_ALPHA_LO  = 2'd1,
        CFG_ALPHA_HI  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_POP
    } t_state;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] t_digit_stack;

    function automatic logic [CHAR_W-1:0] symbol_at(
        input logic [VALUE_W-1:0] lo,
        input logic [VALUE_W-1:0] hi,
        input logic [DIGIT_W-1:0] idx
    );
        logic [2*VALUE_W-1:0] tbl;
        tbl = {hi, lo};
        return tbl[idx*CHAR_W +: CHAR_W];
    endfunction

    function automatic logic alphabet_ok(
        input logic [BASE_W-1:0]  n,
        input logic [VALUE_W-1:0] lo,
        input logic [VALUE_W-1:0] hi
    );
        logic [2*VALUE_W-1:0] tbl;
        logic                 ok;
        logic [CHAR_W-1:0]    ci;
        tbl = {hi, lo};
        ok  = (n >= BASE_W'(2)) && (n <= BASE_W'(MAX_BASE));
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            ci = tbl[i*CHAR_W +: CHAR_W];
            if (BASE_W'(i) < n) begin
                if (ci == CHAR_PLUS || ci == CHAR_MINUS) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
                    if (BASE_W'(j) < n && tbl[j*CHAR_W +: CHAR_W] == ci) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

// ----- rtl/integer_to_radix_digits.sv -----
// Channel  Dir  Handshake                 Payload
// s        in   i_s_tvalid / o_s_tready   tdata: value_bits[63:0]; tuser: opcode
// m        out  o_m_tvalid / i_m_tready   tdata: out_char[7:0]; tlast: last_char
// cfg      in   i_cfg_valid / o_cfg_ready index[1:0], data[63:0]
//
// Digits come from a bit-serial restoring divider; then one character (sign
// included) goes out per cycle while the output is taken. Reset is
// synchronous, active low; config comes back to base 10, "0".."9". Output
// stalls hold the character stage; input is taken again once the last
// character is loaded, and not in the cycle right after a config write.
module integer_to_radix_digits (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [itrd_pkg::VALUE_W-1:0]          i_s_tdata,   // value_bits
    input  logic                                  i_s_tuser,   // opcode
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [itrd_pkg::CHAR_W-1:0]           o_m_tdata,   // out_char
    output logic                                  o_m_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [itrd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [itrd_pkg::VALUE_W-1:0]          i_cfg_data
);

    itrd_pkg::t_state                    r_state,    n_state;
    logic [itrd_pkg::VALUE_W-1:0]        r_mag,      n_mag;
    logic [itrd_pkg::DIGIT_W-1:0]        r_rem,      n_rem;
    logic [itrd_pkg::BIT_CNT_W-1:0]      r_bit_cnt,  n_bit_cnt;
    logic                                r_qnz,      n_qnz;
    logic                                r_neg,      n_neg;
    itrd_pkg::t_digit_stack              r_stk,      n_stk;
    logic [itrd_pkg::CNT_W-1:0]          r_cnt,      n_cnt;
    logic                                r_ov,       n_ov;
    logic [itrd_pkg::CHAR_W-1:0]         r_och,      n_och;
    logic                                r_olast,    n_olast;
    logic [itrd_pkg::BASE_W-1:0]         r_base_len;
    logic [itrd_pkg::VALUE_W-1:0]        r_alpha_lo;
    logic [itrd_pkg::VALUE_W-1:0]        r_alpha_hi;
    logic                                r_alpha_ok;
    logic                                r_cfg_hold;

    logic                                s_acc;
    logic                                out_free;
    logic [itrd_pkg::BASE_W-1:0]         trial;
    logic [itrd_pkg::BASE_W-1:0]         diff;
    logic                                ge;
    logic [itrd_pkg::DIGIT_W-1:0]        rem_nx;
    logic [itrd_pkg::HALF_W-1:0]         low;
    logic [itrd_pkg::HALF_W-1:0]         mag32;

    assign o_s_tready  = (r_state == itrd_pkg::S_IDLE) && !r_cfg_hold;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_och;
    assign o_m_tlast   = r_olast;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ov || i_m_tready;

    // one restoring step per cycle
    assign trial  = {r_rem, r_mag[itrd_pkg::VALUE_W-1]};
    assign ge     = trial >= r_base_len;
    assign diff   = trial - r_base_len;
    assign rem_nx = ge ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];

    assign low   = i_s_tdata[itrd_pkg::HALF_W-1:0];
    assign mag32 = low[itrd_pkg::HALF_W-1] ? (~low + itrd_pkg::HALF_W'(1)) : low;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_rem     = r_rem;
        n_bit_cnt = r_bit_cnt;
        n_qnz     = r_qnz;
        n_neg     = r_neg;
        n_stk     = r_stk;
        n_cnt     = r_cnt;
        n_ov      = r_ov && !i_m_tready;
        n_och     = r_och;
        n_olast   = r_olast;

        unique case (r_state)
            itrd_pkg::S_IDLE: begin
                if (s_acc && r_alpha_ok) begin
                    if (i_s_tuser == itrd_pkg::OP_SIGNED32) begin
                        n_mag = {{(itrd_pkg::VALUE_W-itrd_pkg::HALF_W){1'b0}}, mag32};
                        n_neg = low[itrd_pkg::HALF_W-1];
                    end else begin
                        n_mag = i_s_tdata;
                        n_neg = 1'b0;
                    end
                    n_rem     = '0;
                    n_bit_cnt = '0;
                    n_qnz     = 1'b0;
                    n_cnt     = '0;
                    n_state   = itrd_pkg::S_DIV;
                end
            end
            itrd_pkg::S_DIV: begin
                n_mag     = {r_mag[itrd_pkg::VALUE_W-2:0], ge};
                n_rem     = rem_nx;
                n_qnz     = r_qnz || ge;
                n_bit_cnt = r_bit_cnt + itrd_pkg::BIT_CNT_W'(1);
                if (r_bit_cnt == itrd_pkg::BIT_CNT_W'(itrd_pkg::VALUE_W - 1)) begin
                    n_stk = {r_stk[itrd_pkg::MAX_DIGITS-2:0], rem_nx};
                    n_cnt = r_cnt + itrd_pkg::CNT_W'(1);
                    n_rem = '0;
                    n_qnz = 1'b0;
                    if (!(r_qnz || ge)
                        || r_cnt == itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS - 1)) begin
                        n_state = r_neg ? itrd_pkg::S_SIGN : itrd_pkg::S_POP;
                    end
                end
            end
            itrd_pkg::S_SIGN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_och   = itrd_pkg::CHAR_MINUS;
                    n_olast = 1'b0;
                    n_state = itrd_pkg::S_POP;
                end
            end
            itrd_pkg::S_POP: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_och   = itrd_pkg::symbol_at(r_alpha_lo, r_alpha_hi, r_stk[0]);
                    n_olast = (r_cnt == itrd_pkg::CNT_W'(1));
                    n_cnt   = r_cnt - itrd_pkg::CNT_W'(1);
                    n_stk   = {{itrd_pkg::DIGIT_W{1'b0}}, r_stk[itrd_pkg::MAX_DIGITS-1:1]};
                    if (r_cnt == itrd_pkg::CNT_W'(1)) begin
                        n_state = itrd_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = itrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itrd_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_rem     <= n_rem;
        r_bit_cnt <= n_bit_cnt;
        r_qnz     <= n_qnz;
        r_neg     <= n_neg;
        r_stk     <= n_stk;
        r_och     <= n_och;
        r_olast   <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= itrd_pkg::RST_BASE_LEN;
            r_alpha_lo <= itrd_pkg::RST_ALPHA_LO;
            r_alpha_hi <= itrd_pkg::RST_ALPHA_HI;
            r_alpha_ok <= 1'b1;
            r_cfg_hold <= 1'b0;
        end else begin
            r_alpha_ok <= itrd_pkg::alphabet_ok(r_base_len, r_alpha_lo, r_alpha_hi);
            r_cfg_hold <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    itrd_pkg::CFG_BASE_LEN: r_base_len <= i_cfg_data[itrd_pkg::BASE_W-1:0];
                    itrd_pkg::CFG_ALPHA_LO: r_alpha_lo <= i_cfg_data;
                    itrd_pkg::CFG_ALPHA_HI: r_alpha_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS))
        else $error("digit count above limit");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itrd_pkg::S_POP || r_state == itrd_pkg::S_SIGN) |-> r_cnt != '0)
        else $error("emitting with empty digit stack");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == itrd_pkg::S_DIV |-> {1'b0, r_rem} < r_base_len)
        else $error("partial remainder not below radix");

    a_sign_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == itrd_pkg::S_SIGN |-> r_neg)
        else $error("sign emitted for non-negative value");
`endif

endmodule

// ----- dv/integer_to_radix_digits_test.sv -----
module integer_to_radix_digits_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 20000;
    localparam int SETTLE      = 64 * (itrd_pkg::MAX_DIGITS + 1) + 16;
    localparam int HOLD_CYCLES = 1500;
    localparam int PHASES      = 10;

    localparam logic [itrd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [itrd_pkg::VALUE_W-1:0]   HEX_HI    = 64'h6665646362613938;

    typedef struct packed {
        logic [itrd_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_char;

    typedef enum logic {ROW_WRITE, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic                           op;
        logic [itrd_pkg::CFG_IDX_W-1:0] idx;
        logic [itrd_pkg::VALUE_W-1:0]   bits;
    } t_plan_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [itrd_pkg::VALUE_W-1:0]   i_s_tdata;
    logic                           i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [itrd_pkg::CHAR_W-1:0]    o_m_tdata;
    logic                           o_m_tlast;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [itrd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [itrd_pkg::VALUE_W-1:0]   i_cfg_data;

    t_text_char                   expected_chars[$];
    t_plan_row                    plan[$];
    string                        plan_text[$];
    logic [itrd_pkg::BASE_W-1:0]  radix_reg;
    logic [itrd_pkg::VALUE_W-1:0] alpha_lo_reg;
    logic [itrd_pkg::VALUE_W-1:0] alpha_hi_reg;
    bit                           last_silent;
    bit                           calm;
    bit                           hold_request;
    int                           mismatches;

    integer_to_radix_digits dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // text of one number under the current register settings
    function automatic void predict_text(input logic op,
                                         input logic [itrd_pkg::VALUE_W-1:0] val);
        logic [2*itrd_pkg::VALUE_W-1:0] tbl;
        logic [itrd_pkg::VALUE_W-1:0]   mag;
        logic [itrd_pkg::VALUE_W-1:0]   radix;
        logic [itrd_pkg::DIGIT_W-1:0]   digs[$];
        logic                           ok;
        tbl   = {alpha_hi_reg, alpha_lo_reg};
        radix = itrd_pkg::VALUE_W'(radix_reg);
        ok    = (radix >= 2) && (radix <= itrd_pkg::MAX_BASE);
        for (int i = 0; ok && i < int'(radix); i++) begin
            if (tbl[i*8 +: 8] == itrd_pkg::CHAR_PLUS
                    || tbl[i*8 +: 8] == itrd_pkg::CHAR_MINUS) ok = 1'b0;
            for (int j = i + 1; j < int'(radix); j++)
                if (tbl[j*8 +: 8] == tbl[i*8 +: 8]) ok = 1'b0;
        end
        last_silent = !ok;
        if (!ok) return;
        if (op == itrd_pkg::OP_SIGNED32) begin
            mag = {32'h0, val[31:0]};
            if (val[31]) begin
                expected_chars.push_back('{itrd_pkg::CHAR_MINUS, 1'b0});
                mag = {32'h0, -val[31:0]};
            end
        end else begin
            mag = val;
        end
        do begin
            digs.push_front(itrd_pkg::DIGIT_W'(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digs[k])
            expected_chars.push_back('{tbl[digs[k]*8 +: 8], k == digs.size() - 1});
    endfunction

    task automatic offer_value(input logic op, input logic [itrd_pkg::VALUE_W-1:0] val,
                               input string txt = "");
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 7) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= val;
        do @(posedge i_clk); while (!o_s_tready);
        if (txt.len() > 0) begin
            last_silent = 1'b0;
            for (int i = 0; i < txt.len(); i++)
                expected_chars.push_back('{txt[i], i == txt.len() - 1});
        end else begin
            predict_text(op, val);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
        if (last_silent) begin
            repeat (SETTLE) @(negedge i_clk);
            last_silent = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [itrd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [itrd_pkg::VALUE_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            itrd_pkg::CFG_BASE_LEN: radix_reg    = data[itrd_pkg::BASE_W-1:0];
            itrd_pkg::CFG_ALPHA_LO: alpha_lo_reg = data;
            itrd_pkg::CFG_ALPHA_HI: alpha_hi_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic plan_item(input logic op, input logic [itrd_pkg::VALUE_W-1:0] val,
                             input string txt = "");
        plan.push_back('{ROW_ITEM, op, CFG_SPARE, val});
        plan_text.push_back(txt);
    endtask

    task automatic plan_write(input logic [itrd_pkg::CFG_IDX_W-1:0] idx,
                              input logic [itrd_pkg::VALUE_W-1:0] data);
        plan.push_back('{ROW_WRITE, itrd_pkg::OP_SIGNED32, idx, data});
        plan_text.push_back("");
    endtask

    // receiver: random stalls, calm stretches, one long hold-off
    initial begin : sink
        int hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (calm) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 7);
            end
        end
    end

    always @(posedge i_clk) begin : check_chars
        t_text_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected char: expected none, actual char %h last %b",
                         $time, o_m_tdata, o_m_tlast);
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== o_m_tdata || want.last !== o_m_tlast) begin
                    mismatches++;
                    $display("%0t: expected char %h last %b, actual char %h last %b",
                             $time, want.ch, want.last, o_m_tdata, o_m_tlast);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [2*itrd_pkg::VALUE_W-1:0] tbl;
        logic [255:0]                   used;
        logic [7:0]                     b;
        logic [itrd_pkg::VALUE_W-1:0]   val;
        int                             radix;
        int                             count;
        int                             j;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tuser    = 1'b0;
        i_s_tdata    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = itrd_pkg::CFG_BASE_LEN;
        i_cfg_data   = '0;
        radix_reg    = itrd_pkg::RST_BASE_LEN;
        alpha_lo_reg = itrd_pkg::RST_ALPHA_LO;
        alpha_hi_reg = itrd_pkg::RST_ALPHA_HI;
        last_silent  = 1'b0;
        calm         = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: decimal after reset
        plan_item(itrd_pkg::OP_SIGNED32,   64'h0, "0");
        plan_item(itrd_pkg::OP_SIGNED32,   64'h0000_0000_7FFF_FFFF, "2147483647");
        plan_item(itrd_pkg::OP_SIGNED32,   64'h0000_0000_8000_0000, "-2147483648");
        plan_item(itrd_pkg::OP_SIGNED32,   64'h0000_0000_FFFF_FFFF, "-1");
        plan_item(itrd_pkg::OP_SIGNED32,   64'hDEAD_BEEF_0000_002A, "42");
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'h0, "0");
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF,
                  "18446744073709551615");
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'h8000_0000_0000_0000,
                  "9223372036854775808");
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'h0000_0000_8000_0000, "2147483648");
        // hex, then binary
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd16);
        plan_write(itrd_pkg::CFG_ALPHA_HI, HEX_HI);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_item(itrd_pkg::OP_SIGNED32,   64'h0000_0000_8000_0000);
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd2);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_item(itrd_pkg::OP_SIGNED32,   64'hFFFF_FFFF_FFFF_FFFF);
        // write to unused index leaves the radix alone
        plan_write(CFG_SPARE, 64'd10);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd5);
        // radix out of range
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd1);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd7);
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd0);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd7);
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd17);
        plan_item(itrd_pkg::OP_SIGNED32,   64'd7);
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_item(itrd_pkg::OP_SIGNED32,   64'd7);
        // sign symbols and repeats in the alphabet
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd16);
        plan_write(itrd_pkg::CFG_ALPHA_LO, 64'h3736_352D_3332_3130);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd99);
        plan_write(itrd_pkg::CFG_ALPHA_LO, itrd_pkg::RST_ALPHA_LO);
        plan_write(itrd_pkg::CFG_ALPHA_HI, 64'h2B65_6463_6261_3938);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd99);
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd15);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_write(itrd_pkg::CFG_ALPHA_HI, 64'h2B65_6463_6261_3930);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd99);
        // zero byte is an ordinary symbol
        plan_write(itrd_pkg::CFG_BASE_LEN, 64'd16);
        plan_write(itrd_pkg::CFG_ALPHA_LO, 64'h3736_3534_3332_3100);
        plan_write(itrd_pkg::CFG_ALPHA_HI, HEX_HI);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'd0);
        plan_item(itrd_pkg::OP_SIGNED32,   64'h0000_0000_8000_0000);
        plan_item(itrd_pkg::OP_UNSIGNED64, 64'h1000_0000_0000_00F0);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE)
                write_reg(plan[r].idx, plan[r].bits);
            else
                offer_value(plan[r].op, plan[r].bits, plan_text[r]);
        end

        // random phases, each with its own register settings
        for (int p = 0; p < PHASES; p++) begin
            used = '0;
            used[itrd_pkg::CHAR_PLUS]  = 1'b1;
            used[itrd_pkg::CHAR_MINUS] = 1'b1;
            for (int i = 0; i < 16; i++) begin
                do b = 8'($urandom_range(255)); while (used[b]);
                used[b] = 1'b1;
                tbl[i*8 +: 8] = b;
            end
            radix = $urandom_range(2, 16);
            calm  = 1'b0;
            case (p)
                0: begin
                    radix = 10;
                    tbl   = {itrd_pkg::RST_ALPHA_HI, itrd_pkg::RST_ALPHA_LO};
                    count = 50;
                end
                1: begin
                    radix = 16;
                    tbl   = {HEX_HI, itrd_pkg::RST_ALPHA_LO};
                    calm  = 1'b1;
                    count = 40;
                end
                2: begin
                    radix = 2;
                    count = 20;
                end
                7, 8: begin
                    count = 6;
                    case ($urandom_range(3))
                        0: radix = $urandom_range(1) ? $urandom_range(1)
                                                     : $urandom_range(17, 31);
                        1: tbl[$urandom_range(radix - 1)*8 +: 8] = itrd_pkg::CHAR_MINUS;
                        2: tbl[$urandom_range(radix - 1)*8 +: 8] = itrd_pkg::CHAR_PLUS;
                        default: begin
                            j = $urandom_range(1, radix - 1);
                            tbl[j*8 +: 8] = tbl[$urandom_range(j - 1)*8 +: 8];
                        end
                    endcase
                end
                default: count = 15;
            endcase
            write_reg(itrd_pkg::CFG_BASE_LEN, itrd_pkg::VALUE_W'(radix));
            write_reg(itrd_pkg::CFG_ALPHA_LO, tbl[itrd_pkg::VALUE_W-1:0]);
            write_reg(itrd_pkg::CFG_ALPHA_HI, tbl[2*itrd_pkg::VALUE_W-1:itrd_pkg::VALUE_W]);

            for (int n = 0; n < count; n++) begin
                if (p == 0 && n == 10) hold_request = 1'b1;
                if (p == 1 && n == 20) wait_drained();
                case ($urandom_range(3))
                    0: val = itrd_pkg::VALUE_W'($urandom_range(255));
                    1: val = {$urandom, $urandom >> $urandom_range(31)};
                    2: val = {$urandom, $urandom} >> $urandom_range(63);
                    default: begin
                        case ($urandom_range(4))
                            0: val = '0;
                            1: val = '1;
                            2: val = 64'h8000_0000_0000_0000;
                            3: val = {$urandom, 32'h8000_0000};
                            default: val = {$urandom, 32'h7FFF_FFFF};
                        endcase
                    end
                endcase
                offer_value(logic'($urandom_range(1)), val);
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (expected_chars.size() != 0)
                $display("%0t: %0d expected chars never arrived", $time,
                         expected_chars.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/itrd_pkg.sv
rtl/integer_to_radix_digits.sv
dv/integer_to_radix_digits_test.sv
